// ----- hdl/i2cm_pkg.sv -----
// Package: phase codes, command codes and shared types for the I2C master.
package i2cm_pkg;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_S_REL  = 5'd1;
  localparam logic [4:0] PH_S_D1   = 5'd2;
  localparam logic [4:0] PH_S_D2   = 5'd3;
  localparam logic [4:0] PH_S_D3   = 5'd4;
  localparam logic [4:0] PH_W_D1   = 5'd5;
  localparam logic [4:0] PH_W_CLK  = 5'd6;
  localparam logic [4:0] PH_W_D2   = 5'd7;
  localparam logic [4:0] PH_WA_D1  = 5'd8;
  localparam logic [4:0] PH_WA_CLK = 5'd9;
  localparam logic [4:0] PH_WA_D2  = 5'd10;
  localparam logic [4:0] PH_WA_D3  = 5'd11;
  localparam logic [4:0] PH_W_WAIT = 5'd12;
  localparam logic [4:0] PH_R_CLK  = 5'd13;
  localparam logic [4:0] PH_R_D1   = 5'd14;
  localparam logic [4:0] PH_R_D2   = 5'd15;
  localparam logic [4:0] PH_RA_D1  = 5'd16;
  localparam logic [4:0] PH_RA_CLK = 5'd17;
  localparam logic [4:0] PH_RA_D2  = 5'd18;
  localparam logic [4:0] PH_RA_D3  = 5'd19;
  localparam logic [4:0] PH_P_D1   = 5'd20;
  localparam logic [4:0] PH_P_CLK  = 5'd21;
  localparam logic [4:0] PH_P_D2   = 5'd22;
  localparam logic [4:0] PH_P_D3   = 5'd23;
  localparam logic [4:0] PH_RC_D1  = 5'd24;
  localparam logic [4:0] PH_RC_CLK = 5'd25;
  localparam logic [4:0] PH_RC_D2  = 5'd26;

  localparam logic [1:0] FN_PROBE   = 2'd0;
  localparam logic [1:0] FN_WRITE   = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;
  localparam logic [1:0] FN_RECOVER = 2'd3;

  localparam logic       CFG_HALF_PERIOD = 1'b0;
  localparam logic       CFG_STRETCH     = 1'b1;

  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [3:0] RECOVERY_PULSES = 4'd9;

  typedef struct packed {
    logic [7:0] count;
    logic [7:0] reg_addr;
    logic [6:0] dev_addr;
    logic [1:0] func;
  } cmd_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy;
    logic       done;
    logic       success;
    logic [7:0] read_data;
    logic       read_valid;
    logic       write_data_request;
  } res_t;

endpackage

// ----- hdl/i2cm_out_reg.sv -----
// Output skid stage: result register with a spare slot so the input side keeps flowing.
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic valid_r, skid_r;
  res_t data_r, skid_data_r;
  logic pop;

  assign pop       = valid_r & ~out_stall;
  assign full      = skid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      skid_r  <= 1'b0;
    end else begin
      if (!valid_r || pop) begin
        valid_r <= skid_r | push;
        skid_r  <= 1'b0;
      end else if (push) begin
        skid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!valid_r || pop) begin
      data_r <= skid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ----- hdl/i2c_master_register_access.sv -----
// Top level: I2C master controller, one bus sample per request, one result per request.
//
//  channel | handshake        | payload
//  in_     | in_valid/stall   | command fields and sampled SCL/SDA
//  out_    | out_valid/stall  | line drives, status, read byte
//  cfg_    | cfg_valid/ready  | cfg_index, cfg_data (half period, stretch timeout)
//
// One request is taken per cycle while in_stall is low; its result is registered.
// The state update is a single registered step per request.
// Synchronous active-low reset puts the bus controller idle, lines released.
// in_stall rises only while both output slots are full.
module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int TIMEOUT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_func,
  input  logic [6:0]  in_dev_address,
  input  logic [7:0]  in_reg_address,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_write_data,
  input  logic        in_write_data_valid,
  input  logic        in_scl_level,
  input  logic        in_sda_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_pull_low,
  output logic        out_sda_pull_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_success,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_write_data_request
);

  logic [15:0] half_period_r;
  logic [TIMEOUT_BITS-1:0] stretch_timeout_r;
  logic [4:0]  phase_r, phase_nxt;
  logic [15:0] hp_cnt_r, hp_cnt_nxt;
  logic [TIMEOUT_BITS-1:0] st_cnt_r, st_cnt_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  shift_r, shift_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        ok_r, ok_nxt;
  logic [3:0]  pulse_r, pulse_nxt;
  logic [2:0]  stage_r, stage_nxt;
  logic        ack_r, ack_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        o_done, o_success, o_rvalid;
  logic [7:0]  o_rdata;
  logic        ev, timeout, accept, full;
  logic [23:0] st_load;
  res_t        res;
  res_t        out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid & ~full;
  assign st_load   = cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r     <= 16'd250;
      stretch_timeout_r <= TIMEOUT_BITS'(24'd10000);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HALF_PERIOD) half_period_r <= cfg_data[15:0];
      else stretch_timeout_r <= TIMEOUT_BITS'(st_load);
    end
  end

  function automatic logic is_clk(input logic [4:0] p);
    return p == PH_S_REL || p == PH_W_CLK || p == PH_WA_CLK || p == PH_R_CLK ||
           p == PH_RA_CLK || p == PH_P_CLK || p == PH_RC_CLK;
  endfunction

  always_comb begin
    phase_nxt = phase_r; hp_cnt_nxt = hp_cnt_r; st_cnt_nxt = st_cnt_r;
    bit_cnt_nxt = bit_cnt_r; bytes_left_nxt = bytes_left_r; shift_nxt = shift_r;
    cmd_nxt = cmd_r; ok_nxt = ok_r; pulse_nxt = pulse_r; stage_nxt = stage_r;
    ack_nxt = ack_r; scl_nxt = scl_r; sda_nxt = sda_r;
    o_done = 1'b0; o_success = 1'b0; o_rvalid = 1'b0; o_rdata = 8'd0;
    ev = 1'b0; timeout = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (in_cmd_valid) begin
        cmd_nxt = '{count: in_byte_count, reg_addr: in_reg_address,
                    dev_addr: in_dev_address, func: in_func};
        ok_nxt = 1'b1; stage_nxt = 3'd0; bytes_left_nxt = in_byte_count;
        if (in_func == FN_READ && in_byte_count == 8'd0) begin
          o_done = 1'b1;
        end else if (in_func == FN_RECOVER) begin
          sda_nxt = 1'b0; pulse_nxt = 4'd0; scl_nxt = 1'b1;
          phase_nxt = PH_RC_D1; hp_cnt_nxt = half_period_r;
        end else begin
          sda_nxt = 1'b0; phase_nxt = PH_S_REL; scl_nxt = 1'b0;
          st_cnt_nxt = stretch_timeout_r;
        end
      end
    end else if (phase_r == PH_W_WAIT) begin
      if (in_write_data_valid) begin
        shift_nxt = in_write_data; bit_cnt_nxt = 4'd0; sda_nxt = ~in_write_data[7];
        phase_nxt = PH_W_D1; hp_cnt_nxt = half_period_r;
      end
    end else if (is_clk(phase_r)) begin
      if (in_scl_level) ev = 1'b1;
      else if (st_cnt_r == '0) begin ev = 1'b1; timeout = 1'b1; end
      else st_cnt_nxt = st_cnt_r - 1'b1;
    end else begin
      if (hp_cnt_r > 16'd1) hp_cnt_nxt = hp_cnt_r - 16'd1;
      else ev = 1'b1;
    end

    if (ev) begin
      // Actions written inline; "delay" loads the half period, "clk" releases SCL.
      unique case (phase_r)
        PH_S_REL: begin
          if (timeout) begin
            ok_nxt = 1'b0;
            if (stage_r == 3'd0) begin
              sda_nxt = 1'b0; pulse_nxt = 4'd0; scl_nxt = 1'b1; phase_nxt = PH_RC_D1;
            end else begin
              sda_nxt = 1'b1; phase_nxt = PH_P_D1;
            end
            hp_cnt_nxt = half_period_r;
          end else begin
            phase_nxt = PH_S_D1; hp_cnt_nxt = half_period_r;
          end
        end
        PH_S_D1: begin
          if (!in_sda_level) begin
            ok_nxt = 1'b0;
            if (stage_r == 3'd0) begin
              sda_nxt = 1'b0; pulse_nxt = 4'd0; scl_nxt = 1'b1; phase_nxt = PH_RC_D1;
            end else begin
              sda_nxt = 1'b1; phase_nxt = PH_P_D1;
            end
          end else begin
            sda_nxt = 1'b1; phase_nxt = PH_S_D2;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_S_D2: begin scl_nxt = 1'b1; phase_nxt = PH_S_D3; hp_cnt_nxt = half_period_r; end
        PH_W_D1, PH_WA_D1, PH_RA_D1, PH_P_D1, PH_RC_D1: begin
          phase_nxt = phase_r + 5'd1; scl_nxt = 1'b0; st_cnt_nxt = stretch_timeout_r;
        end
        PH_W_CLK, PH_R_CLK: begin
          if (timeout) begin
            ok_nxt = 1'b0; scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_P_D1;
          end else begin
            phase_nxt = phase_r + 5'd1;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_W_D2: begin
          scl_nxt = 1'b1; shift_nxt = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (bit_cnt_nxt >= BITS_PER_BYTE) begin
            sda_nxt = 1'b0; phase_nxt = PH_WA_D1;
          end else begin
            sda_nxt = ~shift_r[6]; phase_nxt = PH_W_D1;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_WA_CLK: begin
          if (timeout) begin
            ok_nxt = 1'b0; scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_P_D1;
          end else begin
            ack_nxt = ~in_sda_level; phase_nxt = PH_WA_D2;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_WA_D2: begin scl_nxt = 1'b1; phase_nxt = PH_WA_D3; hp_cnt_nxt = half_period_r; end
        PH_R_D1: begin
          shift_nxt = {shift_r[6:0], in_sda_level}; scl_nxt = 1'b1;
          phase_nxt = PH_R_D2; hp_cnt_nxt = half_period_r;
        end
        PH_R_D2: begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (bit_cnt_nxt >= BITS_PER_BYTE) begin
            sda_nxt = bytes_left_r > 8'd1; phase_nxt = PH_RA_D1; hp_cnt_nxt = half_period_r;
          end else begin
            phase_nxt = PH_R_CLK; scl_nxt = 1'b0; st_cnt_nxt = stretch_timeout_r;
          end
        end
        PH_RA_CLK: begin
          if (timeout) begin
            ok_nxt = 1'b0; scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_P_D1;
          end else begin
            phase_nxt = PH_RA_D2;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_RA_D2: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; o_rvalid = 1'b1; o_rdata = shift_r;
          phase_nxt = PH_RA_D3; hp_cnt_nxt = half_period_r;
        end
        PH_P_CLK: begin phase_nxt = PH_P_D2; hp_cnt_nxt = half_period_r; end
        PH_P_D2: begin sda_nxt = 1'b0; phase_nxt = PH_P_D3; hp_cnt_nxt = half_period_r; end
        PH_P_D3: begin phase_nxt = PH_IDLE; o_done = 1'b1; o_success = ok_r; end
        PH_RC_CLK: begin phase_nxt = PH_RC_D2; hp_cnt_nxt = half_period_r; end
        PH_RC_D2: begin
          pulse_nxt = pulse_r + 4'd1;
          if (pulse_nxt >= RECOVERY_PULSES) begin
            sda_nxt = 1'b1; phase_nxt = PH_P_D1;
          end else begin
            scl_nxt = 1'b1; phase_nxt = PH_RC_D1;
          end
          hp_cnt_nxt = half_period_r;
        end
        PH_S_D3, PH_WA_D3, PH_RA_D3: begin
          if (phase_r == PH_WA_D3 && !ack_r) begin
            ok_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = PH_P_D1; hp_cnt_nxt = half_period_r;
          end else if (stage_r == 3'd0 && cmd_r.func != FN_RECOVER) begin
            stage_nxt = 3'd1; shift_nxt = {cmd_r.dev_addr, 1'b0}; bit_cnt_nxt = 4'd0;
            sda_nxt = ~cmd_r.dev_addr[6]; phase_nxt = PH_W_D1; hp_cnt_nxt = half_period_r;
          end else if (cmd_r.func == FN_WRITE) begin
            if (stage_r == 3'd1) begin
              stage_nxt = 3'd2; shift_nxt = cmd_r.reg_addr; bit_cnt_nxt = 4'd0;
              sda_nxt = ~cmd_r.reg_addr[7]; phase_nxt = PH_W_D1;
              hp_cnt_nxt = half_period_r;
            end else begin
              if (stage_r == 3'd3 && bytes_left_r != 8'd0)
                bytes_left_nxt = bytes_left_r - 8'd1;
              stage_nxt = 3'd3;
              if (bytes_left_nxt != 8'd0) phase_nxt = PH_W_WAIT;
              else begin
                sda_nxt = 1'b1; phase_nxt = PH_P_D1; hp_cnt_nxt = half_period_r;
              end
            end
          end else if (cmd_r.func == FN_READ) begin
            case (stage_r)
              3'd1: begin
                stage_nxt = 3'd2; shift_nxt = cmd_r.reg_addr; bit_cnt_nxt = 4'd0;
                sda_nxt = ~cmd_r.reg_addr[7]; phase_nxt = PH_W_D1;
                hp_cnt_nxt = half_period_r;
              end
              3'd2: begin
                stage_nxt = 3'd3; sda_nxt = 1'b0; phase_nxt = PH_S_REL;
                scl_nxt = 1'b0; st_cnt_nxt = stretch_timeout_r;
              end
              3'd3: begin
                stage_nxt = 3'd4; shift_nxt = {cmd_r.dev_addr, 1'b1}; bit_cnt_nxt = 4'd0;
                sda_nxt = ~cmd_r.dev_addr[6]; phase_nxt = PH_W_D1;
                hp_cnt_nxt = half_period_r;
              end
              3'd4: begin
                stage_nxt = 3'd5; shift_nxt = 8'd0; bit_cnt_nxt = 4'd0; sda_nxt = 1'b0;
                phase_nxt = PH_R_CLK; scl_nxt = 1'b0; st_cnt_nxt = stretch_timeout_r;
              end
              default: begin
                if (bytes_left_r != 8'd0) bytes_left_nxt = bytes_left_r - 8'd1;
                if (bytes_left_nxt != 8'd0) begin
                  shift_nxt = 8'd0; bit_cnt_nxt = 4'd0; sda_nxt = 1'b0;
                  phase_nxt = PH_R_CLK; scl_nxt = 1'b0; st_cnt_nxt = stretch_timeout_r;
                end else begin
                  sda_nxt = 1'b1; phase_nxt = PH_P_D1; hp_cnt_nxt = half_period_r;
                end
              end
            endcase
          end else begin
            sda_nxt = 1'b1; phase_nxt = PH_P_D1; hp_cnt_nxt = half_period_r;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; hp_cnt_r <= '0; st_cnt_r <= '0; bit_cnt_r <= '0;
      bytes_left_r <= '0; shift_r <= '0; cmd_r <= '0; ok_r <= 1'b1; pulse_r <= '0;
      stage_r <= '0; ack_r <= 1'b0; scl_r <= 1'b0; sda_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt; hp_cnt_r <= hp_cnt_nxt; st_cnt_r <= st_cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt; bytes_left_r <= bytes_left_nxt; shift_r <= shift_nxt;
      cmd_r <= cmd_nxt; ok_r <= ok_nxt; pulse_r <= pulse_nxt; stage_r <= stage_nxt;
      ack_r <= ack_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
    end
  end

  assign res = '{scl_pull_low: scl_nxt, sda_pull_low: sda_nxt,
                 busy: phase_nxt != PH_IDLE, done: o_done, success: o_success,
                 read_data: o_rdata, read_valid: o_rvalid,
                 write_data_request: phase_nxt == PH_W_WAIT};

  i2cm_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(accept), .push_data(res), .full(full),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  assign out_scl_pull_low       = out_data.scl_pull_low;
  assign out_sda_pull_low       = out_data.sda_pull_low;
  assign out_busy_res           = out_data.busy;
  assign out_done_res           = out_data.done;
  assign out_success            = out_data.success;
  assign out_read_data          = out_data.read_data;
  assign out_read_valid         = out_data.read_valid;
  assign out_write_data_request = out_data.write_data_request;

endmodule
